@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/sha256_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;

  typedef logic [31:0] word_t;
  typedef logic [511:0] block_t;

  // One queued compression job from the front to the back.
  typedef struct packed {
    block_t block;
    logic   final_blk;
  } job_t;

  localparam word_t InitWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t RoundConsts [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte    = 8'h80;
  localparam int unsigned LenOffset = 56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
// Top level of the SHA-256 byte stream hasher.
//
//   port group   direction  transaction
//   in_*         input      one message byte with present and last flags
//   out_*        output     one 64-bit quarter of the digest
//
// A byte is taken each cycle while a block fills; a full block or the padded
// tail is then handed off into a two-entry queue, and waits while the queue is full.
// The compression core loads a block while idle, runs the rounds one round a
// cycle, then adds into the chaining value; the full queue stalls the input.
// A message end passes through a padding state and a hand-off per closing block,
// then the four digest transactions follow.
// Reset (rst_n low, synchronous) loads the initial hash values.
`default_nettype none
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_part,
  output logic [1:0]       out_part_index,
  output logic             out_last_part
);

  logic f_valid, f_ready, c_valid, c_ready;
  job_t f_job, c_job;

  sha256_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_byte_present,
    .in_last_item, .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

  sha256_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(c_valid), .rd_ready(c_ready), .rd_job(c_job));

  sha256_core u_core (
    .clk, .rst_n, .job_valid(c_valid), .job_ready(c_ready), .job(c_job),
    .out_valid, .out_ready, .out_digest_part, .out_part_index, .out_last_part);

endmodule
`default_nettype wire

@@ sv/sha256_front.sv @@
// Front part: packs bytes into blocks, pads the message and queues jobs.
`default_nettype none
module sha256_front
  import sha256_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_byte_present,
  input  wire logic       in_last_item,
  output logic            job_valid,
  input  wire logic       job_ready,
  output job_t            job
);

  typedef enum logic [2:0] {
    F_FILL = 3'b001,
    F_PAD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t     state_r, state_nxt;
  block_t      buf_r, buf_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic        final_r, final_nxt;
  logic        tail_r, tail_nxt;
  logic        spill_r, spill_nxt;
  logic [63:0] bits;

  assign in_ready  = (state_r == F_FILL);
  assign job_valid = (state_r == F_PUSH);
  assign job.block     = buf_r;
  assign job.final_blk = final_r;
  assign bits          = {len_r, 3'b000};

  // Byte placement, padding and job hand-off.
  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    final_nxt = final_r;
    tail_nxt  = tail_r;
    spill_nxt = spill_r;
    unique case (state_r)
      F_FILL: begin
        if (in_valid) begin
          if (in_byte_present) begin
            buf_nxt[511 - 8*fill_r -: 8] = in_data_byte;
            fill_nxt = fill_r + 6'd1;
            len_nxt  = len_r + 61'd1;
          end
          tail_nxt = in_last_item;
          if (in_byte_present && fill_r == 6'd63) begin
            final_nxt = 1'b0;
            state_nxt = F_PUSH;
          end else if (in_last_item) begin
            state_nxt = F_PAD;
          end
        end
      end
      F_PAD: begin
        // Pad byte, zero fill, and the length if it fits in this block.
        buf_nxt[511 - 8*fill_r -: 8] = PadByte;
        for (int i = 0; i < int'(BlockBytes); i++) begin
          if (i > int'(fill_r)) buf_nxt[511 - 8*i -: 8] = 8'h00;
        end
        if (fill_r < 6'(LenOffset)) begin
          buf_nxt[63:0] = bits;
          final_nxt = 1'b1;
          spill_nxt = 1'b0;
        end else begin
          final_nxt = 1'b0;
          spill_nxt = 1'b1;
        end
        tail_nxt  = 1'b0;
        fill_nxt  = 6'd0;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready) begin
          if (final_r) begin
            len_nxt   = '0;
            state_nxt = F_FILL;
          end else if (spill_r) begin
            // Extra block: zeros then the length.
            buf_nxt   = {448'd0, bits};
            final_nxt = 1'b1;
            spill_nxt = 1'b0;
          end else if (tail_r) begin
            // The last byte closed a full block; padding follows in a new one.
            tail_nxt  = 1'b0;
            state_nxt = F_PAD;
          end else begin
            state_nxt = F_FILL;
          end
        end
      end
      default: state_nxt = F_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_FILL;
      fill_r  <= '0;
      len_r   <= '0;
      final_r <= 1'b0;
      tail_r  <= 1'b0;
      spill_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      final_r <= final_nxt;
      tail_r  <= tail_nxt;
      spill_r <= spill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule
`default_nettype wire

@@ sv/sha256_queue.sv @@
// Two-entry job queue between the front and the compression core.
`default_nettype none
module sha256_queue
  import sha256_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire job_t wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_job
);

  job_t       mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job   = mem_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointer and count update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wr_job;
  end

endmodule
`default_nettype wire

@@ sv/sha256_core.sv @@
// Back part: 64-round compression, chaining update and digest output.
`default_nettype none
module sha256_core
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  wire job_t        job,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_part,
  output logic [1:0]       out_part_index,
  output logic             out_last_part
);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_ROUND = 4'b0010,
    C_ADD   = 4'b0100,
    C_EMIT  = 4'b1000
  } cstate_t;

  cstate_t    state_r;
  word_t      chain_r [8];
  word_t      v_r [8];
  word_t      w_r [16];
  logic [5:0] rnd_r;
  logic       final_r;
  logic [1:0] part_r;

  word_t w_cur, w_new, t1, t2, maj, chv;

  assign job_ready = (state_r == C_IDLE);
  assign out_valid = (state_r == C_EMIT);
  assign out_digest_part = {chain_r[{part_r, 1'b0}], chain_r[{part_r, 1'b1}]};
  assign out_part_index  = part_r;
  assign out_last_part   = (part_r == 2'd3);

  // One round: schedule word and working-variable update.
  always_comb begin
    w_new = w_r[0] + sig0(w_r[1]) + w_r[9] + sig1(w_r[14]);
    w_cur = w_r[0];
    chv   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + bsig1(v_r[4]) + chv + RoundConsts[rnd_r] + w_cur;
    t2    = bsig0(v_r[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      part_r  <= '0;
      final_r <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= InitWords[i];
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 16; i++) w_r[i] <= job.block[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) v_r[i] <= chain_r[i];
            final_r <= job.final_blk;
            rnd_r   <= '0;
            state_r <= C_ROUND;
          end
        end
        C_ROUND: begin
          // Window of 16 schedule words shifts down one each round.
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= w_new;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'(Rounds - 1)) state_r <= C_ADD;
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + v_r[i];
          part_r  <= '0;
          state_r <= final_r ? C_EMIT : C_IDLE;
        end
        C_EMIT: begin
          if (out_ready) begin
            part_r <= part_r + 2'd1;
            if (part_r == 2'd3) begin
              for (int i = 0; i < 8; i++) chain_r[i] <= InitWords[i];
              state_r <= C_IDLE;
            end
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/sha256_checker.sv @@
// Port-level checker for the hasher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module sha256_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_digest_part,
  input wire logic [1:0]  out_part_index,
  input wire logic        out_last_part
);
  logic       idx_top, mid_fire, idx_ok, out_wait;
  logic [1:0] idx_exp_r;

  // Expected index of the part after the current one.
  always_ff @(posedge clk) begin
    idx_exp_r <= out_part_index + 2'd1;
  end

  assign idx_top  = (out_part_index == 2'd3);
  assign mid_fire = out_valid && out_ready && !out_last_part;
  assign idx_ok   = out_valid && (out_part_index == idx_exp_r);
  assign out_wait = out_valid && !out_ready;

  `CHK_IMPL(a_last_idx, clk, rst_n, out_valid, out_last_part == idx_top, "bad last flag")
  `CHK_NEXT(a_idx_step, clk, rst_n, mid_fire, idx_ok, "part order broken")
  `CHK_NEXT(a_hold, clk, rst_n, out_wait, out_valid && $stable(out_digest_part), "part changed")
endmodule

bind sha256_stream_hasher sha256_checker u_chk (.*);
`default_nettype wire
